/* sv/rrbb_pkg.sv */
// Package for the rotated rectangle bounding box core: field widths, angle
// constants, quadrant codes and the quarter-wave sine table generator.
// No dependencies.
`default_nettype none

package rrbb_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF     = 15;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // Fixed field widths
    localparam int BOX_BITS   = 18;
    localparam int ANGLE_BITS = 9;
    localparam int REM_BITS   = 7;   // remainder of the angle within a quadrant, 0..89

    localparam int ANGLE_FULL    = 360;
    localparam int ANGLE_QUARTER = 90;
    localparam int ANGLE_HALF    = 180;

    // Fixed-point series used to build the sine table at elaboration
    localparam int     SERIES_FRAC  = 30;
    localparam longint PI_SERIES    = 64'sd3373259426;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    // sin(deg degrees) with frac_bits fraction bits, deg in 0..90.
    // Taylor series at 30 fraction bits, rounded half up, clamped to [0, 1.0].
    function automatic longint rrbb_rom_sine(input int deg, input int frac_bits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint res;
        int     shift;
        x     = (longint'(deg) * PI_SERIES) / ANGLE_HALF;
        x2    = (x * x) >>> SERIES_FRAC;
        term  = x;
        sum   = x;
        shift = SERIES_FRAC - frac_bits;
        // Twelve alternating terms; term n is divided by 2n*(2n+1)
        term = ((term * x2) >>> SERIES_FRAC) / 6;
        sum  = sum - term;
        term = ((term * x2) >>> SERIES_FRAC) / 20;
        sum  = sum + term;
        term = ((term * x2) >>> SERIES_FRAC) / 42;
        sum  = sum - term;
        term = ((term * x2) >>> SERIES_FRAC) / 72;
        sum  = sum + term;
        term = ((term * x2) >>> SERIES_FRAC) / 110;
        sum  = sum - term;
        term = ((term * x2) >>> SERIES_FRAC) / 156;
        sum  = sum + term;
        term = ((term * x2) >>> SERIES_FRAC) / 210;
        sum  = sum - term;
        term = ((term * x2) >>> SERIES_FRAC) / 272;
        sum  = sum + term;
        term = ((term * x2) >>> SERIES_FRAC) / 342;
        sum  = sum - term;
        term = ((term * x2) >>> SERIES_FRAC) / 420;
        sum  = sum + term;
        term = ((term * x2) >>> SERIES_FRAC) / 506;
        sum  = sum - term;
        term = ((term * x2) >>> SERIES_FRAC) / 600;
        sum  = sum + term;
        if (sum < 0) begin
            sum = 0;
        end
        res = (sum + (longint'(1) <<< (shift - 1))) >>> shift;
        if (res > (longint'(1) <<< frac_bits)) begin
            res = longint'(1) <<< frac_bits;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/rotated_rect_bounding_box_core.sv */
// Rotated rectangle bounding box core; depends on rrbb_pkg.
// Five register stages: input, sine/cosine and offsets, products, rotated corners,
// bounding box; a request accepted on the slave side passes through each in order
// to the master side. Throughput: one request per cycle while the master side is ready.
// Back-pressure stalls only full stages whose successor cannot move.
// Synchronous active-low reset empties the pipeline; data registers are not reset.
`default_nettype none

module rotated_rect_bounding_box_core #(
    parameter int COORD_BITS     = rrbb_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = rrbb_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    // Slave side: one rectangle request per handshake
    input  wire logic                                          i_s_axis_tvalid,
    output      logic                                          o_s_axis_tready,
    // tdata, lowest bit first: corner_x, corner_y, rect_width, rect_height,
    // angle_deg, pivot_x, pivot_y, zero fill to whole bytes
    input  wire logic [((6*COORD_BITS+rrbb_pkg::ANGLE_BITS-2+7)/8)*8-1:0] i_s_axis_tdata,
    // Master side: one bounding box per request
    output      logic                                          o_m_axis_tvalid,
    input  wire logic                                          i_m_axis_tready,
    // tdata, lowest bit first: box_x, box_y, box_w, box_h
    output      logic [4*rrbb_pkg::BOX_BITS-1:0]               o_m_axis_tdata
);
    import rrbb_pkg::*;

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int CB  = COORD_BITS;
    localparam int TB  = TRIG_FRAC_BITS;
    localparam int TW  = TB + 2;          // signed sine/cosine, 1.0 held exactly
    localparam int DW  = CB + 2;          // signed corner offset from the pivot
    localparam int PW  = DW + TW;         // signed product
    localparam int FW  = PW + 2;          // signed rotated coordinate before truncation
    localparam int RW  = (CB + 7 > BOX_BITS) ? CB + 7 : BOX_BITS; // truncated coordinate
    localparam int NST = 5;               // pipeline stages

    // tdata field offsets
    localparam int OFS_CY  = CB;
    localparam int OFS_W   = 2 * CB;
    localparam int OFS_H   = 3 * CB - 1;
    localparam int OFS_ANG = 4 * CB - 2;
    localparam int OFS_PX  = OFS_ANG + ANGLE_BITS;
    localparam int OFS_PY  = OFS_PX + CB;

    localparam logic signed [FW-1:0] TRUNC_BIAS = {{(FW - TB){1'b0}}, {TB{1'b1}}};

    // ------------------------------------------------------------------
    // Quarter-wave sine table, sin(0..90 degrees), built at elaboration
    // ------------------------------------------------------------------
    logic [TW-1:0] w_sin_tab [0:ANGLE_QUARTER];

    for (genvar k = 0; k <= ANGLE_QUARTER; k++) begin : g_sin_tab
        localparam longint SIN_VAL = rrbb_rom_sine(k, TB);
        assign w_sin_tab[k] = TW'(SIN_VAL);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when its
    // contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic signed [CB-1:0]         r_cx, r_cy, r_px0, r_py0;
    logic        [CB-2:0]         r_w, r_h;
    logic        [ANGLE_BITS-1:0] r_ang;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_cx  <= i_s_axis_tdata[0 +: CB];
            r_cy  <= i_s_axis_tdata[OFS_CY +: CB];
            r_w   <= i_s_axis_tdata[OFS_W +: CB - 1];
            r_h   <= i_s_axis_tdata[OFS_H +: CB - 1];
            r_ang <= i_s_axis_tdata[OFS_ANG +: ANGLE_BITS];
            r_px0 <= i_s_axis_tdata[OFS_PX +: CB];
            r_py0 <= i_s_axis_tdata[OFS_PY +: CB];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: fold the angle into a quadrant, look up sine and cosine,
    // and form the two distinct x and y offsets of the corners.
    // ------------------------------------------------------------------
    logic [ANGLE_BITS-1:0] w_ang;
    t_quadrant             w_quad;
    logic [REM_BITS-1:0]   w_rem;
    logic [REM_BITS-1:0]   w_rem_c;
    logic signed [TW-1:0]  w_s0, w_c0;
    logic signed [TW-1:0]  n_sin, n_cos;

    always_comb begin
        // Angles from 360 up wrap once; 9 bits never reach 720.
        if (r_ang >= ANGLE_BITS'(ANGLE_FULL)) begin
            w_ang = r_ang - ANGLE_BITS'(ANGLE_FULL);
        end else begin
            w_ang = r_ang;
        end

        priority if (w_ang < ANGLE_BITS'(ANGLE_QUARTER)) begin
            w_quad = QUAD_0;
            w_rem  = REM_BITS'(w_ang);
        end else if (w_ang < ANGLE_BITS'(2 * ANGLE_QUARTER)) begin
            w_quad = QUAD_1;
            w_rem  = REM_BITS'(w_ang - ANGLE_BITS'(ANGLE_QUARTER));
        end else if (w_ang < ANGLE_BITS'(3 * ANGLE_QUARTER)) begin
            w_quad = QUAD_2;
            w_rem  = REM_BITS'(w_ang - ANGLE_BITS'(2 * ANGLE_QUARTER));
        end else begin
            w_quad = QUAD_3;
            w_rem  = REM_BITS'(w_ang - ANGLE_BITS'(3 * ANGLE_QUARTER));
        end

        w_rem_c = REM_BITS'(ANGLE_QUARTER) - w_rem;
        w_s0    = w_sin_tab[w_rem];
        w_c0    = w_sin_tab[w_rem_c];

        unique case (w_quad)
            QUAD_0: begin
                n_sin = w_s0;
                n_cos = w_c0;
            end
            QUAD_1: begin
                n_sin = w_c0;
                n_cos = -w_s0;
            end
            QUAD_2: begin
                n_sin = -w_s0;
                n_cos = -w_c0;
            end
            QUAD_3: begin
                n_sin = -w_c0;
                n_cos = w_s0;
            end
            default: begin
                n_sin = w_s0;
                n_cos = w_c0;
            end
        endcase
    end

    logic signed [TW-1:0] r_sin, r_cos;
    logic signed [DW-1:0] r_dx0, r_dx1, r_dy0, r_dy1;
    logic signed [CB-1:0] r_px1, r_py1;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
            // Left and right edges, top and bottom edges, relative to the pivot
            r_dx0 <= DW'(r_cx) - DW'(r_px0);
            r_dx1 <= DW'(r_cx) + $signed(DW'(r_w)) - DW'(r_px0);
            r_dy0 <= DW'(r_cy) - DW'(r_py0);
            r_dy1 <= DW'(r_cy) + $signed(DW'(r_h)) - DW'(r_py0);
            r_px1 <= r_px0;
            r_py1 <= r_py0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the eight products, each registered
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_dx0c, r_dx1c, r_dy0s, r_dy1s;
    logic signed [PW-1:0] r_dx0s, r_dx1s, r_dy0c, r_dy1c;
    logic signed [CB-1:0] r_px2, r_py2;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_dx0c <= PW'(r_dx0) * PW'(r_cos);
            r_dx1c <= PW'(r_dx1) * PW'(r_cos);
            r_dy0s <= PW'(r_dy0) * PW'(r_sin);
            r_dy1s <= PW'(r_dy1) * PW'(r_sin);
            r_dx0s <= PW'(r_dx0) * PW'(r_sin);
            r_dx1s <= PW'(r_dx1) * PW'(r_sin);
            r_dy0c <= PW'(r_dy0) * PW'(r_cos);
            r_dy1c <= PW'(r_dy1) * PW'(r_cos);
            r_px2  <= r_px1;
            r_py2  <= r_py1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotated corners, exact sums then truncation toward zero.
    // Corner order: top-left, top-right, bottom-right, bottom-left.
    // ------------------------------------------------------------------
    logic signed [FW-1:0] w_pxs, w_pys;
    logic signed [FW-1:0] w_fx [4];
    logic signed [FW-1:0] w_fy [4];
    logic signed [FW-1:0] w_bx [4];
    logic signed [FW-1:0] w_by [4];
    logic signed [RW-1:0] n_rx [4];
    logic signed [RW-1:0] n_ry [4];

    always_comb begin
        w_pxs = FW'(r_px2) <<< TB;
        w_pys = FW'(r_py2) <<< TB;

        w_fx[0] = w_pxs + FW'(r_dx0c) - FW'(r_dy0s);
        w_fx[1] = w_pxs + FW'(r_dx1c) - FW'(r_dy0s);
        w_fx[2] = w_pxs + FW'(r_dx1c) - FW'(r_dy1s);
        w_fx[3] = w_pxs + FW'(r_dx0c) - FW'(r_dy1s);

        w_fy[0] = w_pys + FW'(r_dx0s) + FW'(r_dy0c);
        w_fy[1] = w_pys + FW'(r_dx1s) + FW'(r_dy0c);
        w_fy[2] = w_pys + FW'(r_dx1s) + FW'(r_dy1c);
        w_fy[3] = w_pys + FW'(r_dx0s) + FW'(r_dy1c);

        for (int i = 0; i < 4; i++) begin
            // Bias negative values up so the arithmetic shift rounds toward zero
            w_bx[i] = w_fx[i] + (w_fx[i][FW-1] ? TRUNC_BIAS : '0);
            w_by[i] = w_fy[i] + (w_fy[i][FW-1] ? TRUNC_BIAS : '0);
            n_rx[i] = RW'(w_bx[i] >>> TB);
            n_ry[i] = RW'(w_by[i] >>> TB);
        end
    end

    logic signed [RW-1:0] r_rx [4];
    logic signed [RW-1:0] r_ry [4];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: bounding box into the output register
    // ------------------------------------------------------------------
    logic signed [RW-1:0] w_minx, w_maxx, w_miny, w_maxy;
    logic signed [RW-1:0] w_spanx, w_spany;

    always_comb begin
        w_minx = r_rx[0];
        w_maxx = r_rx[0];
        w_miny = r_ry[0];
        w_maxy = r_ry[0];
        for (int i = 1; i < 4; i++) begin
            if (r_rx[i] < w_minx) w_minx = r_rx[i];
            if (r_rx[i] > w_maxx) w_maxx = r_rx[i];
            if (r_ry[i] < w_miny) w_miny = r_ry[i];
            if (r_ry[i] > w_maxy) w_maxy = r_ry[i];
        end
        w_spanx = w_maxx - w_minx;
        w_spany = w_maxy - w_miny;
    end

    logic [BOX_BITS-1:0] r_box_x, r_box_y, r_box_w, r_box_h;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            // Keep the low bits; wider coordinate settings wrap here
            r_box_x <= w_minx[BOX_BITS-1:0];
            r_box_y <= w_miny[BOX_BITS-1:0];
            r_box_w <= w_spanx[BOX_BITS-1:0];
            r_box_h <= w_spany[BOX_BITS-1:0];
        end
    end

    assign o_m_axis_tdata = {r_box_h, r_box_w, r_box_y, r_box_x};

endmodule

`default_nettype wire

/* test/rotated_rect_bounding_box_core_test.sv */
// Self-checking bench for rotated_rect_bounding_box_core: drives rectangle requests,
// predicts each bounding box in fixed point and compares it with the master side.
// Depends on rrbb_pkg and the core itself.

module rotated_rect_bounding_box_core_test;
    import rrbb_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int TF = TRIG_FRAC_BITS_DEF;
    localparam int BB = BOX_BITS;
    localparam int AB = ANGLE_BITS;

    // Request layout on the slave tdata, zero fill on top
    localparam int RECT_BITS = 6 * CB + AB - 2;
    localparam int S_BITS    = ((RECT_BITS + 7) / 8) * 8;
    localparam int FILL_BITS = S_BITS - RECT_BITS;

    localparam longint PI_Q30     = 64'sd3373259426;   // pi with 30 fraction bits
    localparam int     Q30        = 30;
    localparam int     SINE_TERMS = 12;

    localparam int DIRECTED_ITEMS = 22;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 1000000;

    // Packed MSB first so the struct maps straight onto tdata, corner_x lowest
    typedef struct packed {
        logic signed [CB-1:0] pivot_y;
        logic signed [CB-1:0] pivot_x;
        logic        [AB-1:0] angle_deg;
        logic        [CB-2:0] rect_height;
        logic        [CB-2:0] rect_width;
        logic signed [CB-1:0] corner_y;
        logic signed [CB-1:0] corner_x;
    } rect_t;

    // Master tdata, lowest bit first: box_x, box_y, box_w, box_h
    typedef struct packed {
        logic        [BB-1:0] box_h;
        logic        [BB-1:0] box_w;
        logic signed [BB-1:0] box_y;
        logic signed [BB-1:0] box_x;
    } box_t;

    // Predicts one box per accepted request and matches results in order.
    class box_scoreboard;
        longint sine_rom[91];
        box_t   pending[$];
        bit     angle_seen[512];
        int     fails;
        int     requests;
        int     boxes;

        function new();
            for (int k = 0; k <= 90; k++) begin
                sine_rom[k] = quarter_sine(k);
            end
            fails    = 0;
            requests = 0;
            boxes    = 0;
        endfunction

        // sin(deg degrees) by series at 30 fraction bits, rounded half up to TF bits
        function longint quarter_sine(int deg);
            longint x;
            longint x2;
            longint term;
            longint acc;
            longint q;
            int     shift;
            x     = (longint'(deg) * PI_Q30) / 180;
            x2    = (x * x) >>> Q30;
            term  = x;
            acc   = x;
            shift = Q30 - TF;
            for (int n = 1; n <= SINE_TERMS; n++) begin
                term = ((term * x2) >>> Q30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            q = (acc + (longint'(1) <<< (shift - 1))) >>> shift;
            if (q > (longint'(1) <<< TF)) begin
                q = longint'(1) <<< TF;
            end
            return q;
        endfunction

        function longint trunc_pixel(longint v);
            if (v < 0) begin
                return -((-v) >>> TF);
            end
            return v >>> TF;
        endfunction

        function box_t rotate_box(rect_t r);
            longint cx, cy, w, h, px, py;
            longint s, c, s0, c0, dx, dy, span;
            longint xs[4];
            longint ys[4];
            longint minx, maxx, miny, maxy;
            int     a;
            int     rem;
            box_t   b;
            cx  = longint'(r.corner_x);
            cy  = longint'(r.corner_y);
            w   = longint'(r.rect_width);
            h   = longint'(r.rect_height);
            px  = longint'(r.pivot_x);
            py  = longint'(r.pivot_y);
            a   = int'(r.angle_deg) % 360;
            rem = a % 90;
            s0  = sine_rom[rem];
            c0  = sine_rom[90 - rem];
            case (t_quadrant'(a / 90))
                QUAD_0: begin
                    s = s0;  c = c0;
                end
                QUAD_1: begin
                    s = c0;  c = -s0;
                end
                QUAD_2: begin
                    s = -s0; c = -c0;
                end
                default: begin
                    s = -c0; c = s0;
                end
            endcase
            xs[0] = cx;     ys[0] = cy;
            xs[1] = cx + w; ys[1] = cy;
            xs[2] = cx + w; ys[2] = cy + h;
            xs[3] = cx;     ys[3] = cy + h;
            for (int i = 0; i < 4; i++) begin
                dx    = xs[i] - px;
                dy    = ys[i] - py;
                xs[i] = trunc_pixel((px <<< TF) + dx * c - dy * s);
                ys[i] = trunc_pixel((py <<< TF) + dx * s + dy * c);
            end
            minx = xs[0]; maxx = xs[0];
            miny = ys[0]; maxy = ys[0];
            for (int i = 1; i < 4; i++) begin
                if (xs[i] < minx) minx = xs[i];
                if (xs[i] > maxx) maxx = xs[i];
                if (ys[i] < miny) miny = ys[i];
                if (ys[i] > maxy) maxy = ys[i];
            end
            b.box_x = minx[BB-1:0];
            b.box_y = miny[BB-1:0];
            span    = maxx - minx;
            b.box_w = span[BB-1:0];
            span    = maxy - miny;
            b.box_h = span[BB-1:0];
            return b;
        endfunction

        function void note_request(rect_t r);
            pending.push_back(rotate_box(r));
            angle_seen[r.angle_deg] = 1'b1;
            requests++;
        endfunction

        function void check_box(box_t got);
            box_t want;
            boxes++;
            if (pending.size() == 0) begin
                $error("box with no request waiting: x %0d y %0d w %0d h %0d",
                       got.box_x, got.box_y, got.box_w, got.box_h);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.box_x !== want.box_x) begin
                $error("box_x: expected %0d, got %0d", want.box_x, got.box_x);
                fails++;
            end
            if (got.box_y !== want.box_y) begin
                $error("box_y: expected %0d, got %0d", want.box_y, got.box_y);
                fails++;
            end
            if (got.box_w !== want.box_w) begin
                $error("box_w: expected %0d, got %0d", want.box_w, got.box_w);
                fails++;
            end
            if (got.box_h !== want.box_h) begin
                $error("box_h: expected %0d, got %0d", want.box_h, got.box_h);
                fails++;
            end
        endfunction

        function int angles_covered();
            int n;
            n = 0;
            foreach (angle_seen[k]) n += angle_seen[k];
            return n;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_valid;
    logic [S_BITS-1:0]   s_data;
    logic                s_ready;
    logic                m_valid;
    logic                m_ready;
    logic [4*BB-1:0]     m_data;

    box_scoreboard sb = new();

    // Shared between the stimulus and the receiver; each is written by one side only
    // at a time and read half a cycle away.
    bit no_idle   = 1'b0;
    bit long_hold = 1'b0;
    int hold_count = 0;

    rotated_rect_bounding_box_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long; none at all in quiet stretches
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rect_t make_rect(int cx, int cy, int w, int h, int ang, int px, int py);
        rect_t r;
        r.corner_x    = cx[CB-1:0];
        r.corner_y    = cy[CB-1:0];
        r.rect_width  = w[CB-2:0];
        r.rect_height = h[CB-2:0];
        r.angle_deg   = ang[AB-1:0];
        r.pivot_x     = px[CB-1:0];
        r.pivot_y     = py[CB-1:0];
        return r;
    endfunction

    // Pick either coordinate extreme, zero or a random value from zero up to hi
    function automatic int edge_coord(int lo, int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            2:       return 0;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    function automatic rect_t random_rect();
        logic [127:0] bits;
        rect_t        r;
        int           mode;
        int           lo;
        int           hi;
        lo   = -(1 << (CB - 1));
        hi   = (1 << (CB - 1)) - 1;
        mode = $urandom_range(0, 9);
        bits = {$urandom, $urandom, $urandom, $urandom};
        r    = bits[RECT_BITS-1:0];
        if (mode >= 6 && mode <= 8) begin
            // small scenes near the origin, where truncation details show
            r = make_rect($urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                          $urandom_range(0, 300), $urandom_range(0, 300), 0,
                          $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512);
        end else if (mode == 9) begin
            r = make_rect(edge_coord(lo, hi), edge_coord(lo, hi),
                          edge_coord(0, hi >> 0) & ((1 << (CB - 1)) - 1),
                          edge_coord(0, hi) & ((1 << (CB - 1)) - 1), 0,
                          edge_coord(lo, hi), edge_coord(lo, hi));
        end
        // Mostly in-range angles; the rest wraps past a full turn
        if ($urandom_range(0, 99) < 80) begin
            r.angle_deg = AB'($urandom_range(0, ANGLE_FULL - 1));
        end else begin
            r.angle_deg = AB'($urandom_range(ANGLE_FULL, (1 << AB) - 1));
        end
        return r;
    endfunction

    // Offer one request after a random gap and hold it until the core takes it.
    task automatic send_rect(input rect_t r);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{FILL_BITS{1'b0}}, r};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    // Note each request at the edge where it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) begin
            sb.note_request(s_data[RECT_BITS-1:0]);
        end
    end

    // Check each box at the edge where it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            sb.check_box(m_data);
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request from the stimulus
    // so the pipeline fills and the core must drop tready.
    initial begin : receiver
        int rx_gap;
        rx_gap  = 0;
        m_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_ready <= 1'b0;
                for (int k = 1; k < LONG_HOLD; k++) begin
                    @(negedge i_clk);
                    hold_count++;
                end
                rx_gap = 0;
            end else if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    // Watchdog: end the run if the regression never drains
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int lo;
        int hi;
        int wmax;
        lo      = -(1 << (CB - 1));
        hi      = (1 << (CB - 1)) - 1;
        wmax    = (1 << (CB - 1)) - 1;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero everything, each quadrant boundary, angles past a full turn,
        // zero-sized rectangles and the coordinate extremes at the worst angles.
        send_rect(make_rect(0, 0, 0, 0, 0, 0, 0));
        send_rect(make_rect(10, 20, 30, 40, 0, 0, 0));
        send_rect(make_rect(10, 20, 30, 40, 90, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 180, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 270, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 359, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 1, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 89, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 360, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 450, 5, -7));
        send_rect(make_rect(10, 20, 30, 40, 511, 5, -7));
        send_rect(make_rect(-3, -3, 0, 25, 33, 0, 0));
        send_rect(make_rect(7, -9, 25, 0, 147, 1, 1));
        send_rect(make_rect(lo, lo, wmax, wmax, 45, hi, hi));
        send_rect(make_rect(lo, lo, wmax, wmax, 135, hi, hi));
        send_rect(make_rect(lo, lo, wmax, wmax, 225, hi, hi));
        send_rect(make_rect(lo, lo, wmax, wmax, 315, hi, hi));
        send_rect(make_rect(hi, hi, wmax, wmax, 45, lo, lo));
        send_rect(make_rect(hi, lo, wmax, 0, 180, lo, hi));
        send_rect(make_rect(lo, hi, 0, wmax, 270, hi, lo));
        send_rect(make_rect(hi, hi, wmax, wmax, 0, lo, lo));
        send_rect(make_rect(lo, lo, 0, 0, 135, lo, lo));

        // Random: a quiet stretch with no idling, and two long receiver hold-offs
        // while the sender keeps offering.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 300 && n < 450);
            if (n == 100 || n == 700) begin
                long_hold = 1'b1;
            end
            send_rect(random_rect());
        end
        @(negedge i_clk);
        s_valid <= 1'b0;

        // Drain: wait for every box, then let the pipeline run empty
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d rectangles over %0d distinct angle codes, %0d boxes compared.",
                 sb.requests, sb.angles_covered(), sb.boxes);
        $display("Receiver held off %0d cycles in long stretches; %0d mismatches.",
                 hold_count, sb.fails);
        if (sb.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* rotated_rect_bounding_box_core.f */
sv/rrbb_pkg.sv
sv/rotated_rect_bounding_box_core.sv
test/rotated_rect_bounding_box_core_test.sv
